// ===== rtl/ochr_pkg.sv =====
`default_nettype none

package ochr_pkg;

  // Geometry
  localparam int MODULES           = 2;
  localparam int INPUTS_PER_MODULE = 2;
  localparam int TOTAL_INPUTS      = MODULES * INPUTS_PER_MODULE;

  // Field and register widths
  localparam int TIME_W   = 32;
  localparam int REG_W    = 20;
  localparam int MOD_W    = 1;
  localparam int INP_W    = 1;
  localparam int BITMAP_W = 2;
  localparam int POS_W    = $clog2(TOTAL_INPUTS);
  localparam int CFG_IDX_W = 2;

  // Register reset values
  localparam logic [REG_W-1:0] MAX_INTERVAL_RST = REG_W'(60000);
  localparam logic [REG_W-1:0] MIN_INTERVAL_RST = REG_W'(4000);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = CFG_IDX_W'(1);

  // Item modes
  localparam logic MODE_STATUS = 1'b0;
  localparam logic MODE_SCAN   = 1'b1;

  typedef enum logic [1:0] {
    PH_INIT = 2'd0,
    PH_SCAN = 2'd1,
    PH_HOLD = 2'd2
  } phase_t;

  typedef struct packed {
    logic [MOD_W-1:0] report_module;
    logic [INP_W-1:0] report_input;
    logic             report_value;
  } report_t;

  typedef struct packed {
    logic                mode;
    logic [TIME_W-1:0]   now_time;
    logic [MOD_W-1:0]    module_index;
    logic [BITMAP_W-1:0] input_bitmap;
  } item_t;

  // Wrapping time compare: deadline has passed when (now - deadline) lies in 1 .. 2^31-1
  function automatic logic time_passed(input logic [TIME_W-1:0] now,
                                       input logic [TIME_W-1:0] deadline);
    logic [TIME_W-1:0] diff;
    diff = now - deadline;
    return (diff != '0) && !diff[TIME_W-1];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/opto_change_heartbeat_reporter_top.sv =====
`default_nettype none

// Opto change reporter with heartbeat. Status items (mode 0) write one
// module's input levels; scan items (mode 1) carry the current time and,
// when not held off, check one input each, round robin. An input is reported
// when its level changed since its last report or when its heartbeat deadline
// has passed; after any report, scans are held off for min_interval. The
// first scan after reset only arms the deadlines. Times wrap modulo 2^32.
// Each item yields zero or one report. Throughput is one item per clock while
// the input is not stalled: an item is registered on entry, evaluated
// combinationally against the per-input state held in flops, and any report
// lands in a one-deep output register. Input stall only rises when a report
// is waiting behind a stalled output; items with no report pass regardless.
// Configuration (index 0 max_interval, index 1 min_interval, others ignored)
// is to be written only while the block is idle.
module opto_change_heartbeat_reporter_top
  import ochr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0]     cfg_wdata,
  // input channel
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire logic                 in_mode,
  input  wire logic [TIME_W-1:0]    in_now_time,
  input  wire logic [MOD_W-1:0]     in_module_index,
  input  wire logic [BITMAP_W-1:0]  in_input_bitmap,
  // result channel
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      logic [MOD_W-1:0]     out_report_module,
  output      logic [INP_W-1:0]     out_report_input,
  output      logic                 out_report_value
);

  logic [REG_W-1:0] max_interval_r;
  logic [REG_W-1:0] min_interval_r;

  // input register
  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r;
  logic    in_xfer;
  logic    adv;

  // core / output slot
  logic    res_valid;
  report_t res;
  logic    out_free;
  report_t out_rep;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_interval_r <= MAX_INTERVAL_RST;
      min_interval_r <= MIN_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_INTERVAL: max_interval_r <= cfg_wdata;
        CFG_MIN_INTERVAL: min_interval_r <= cfg_wdata;
        default: begin
          max_interval_r <= max_interval_r;
        end
      endcase
    end
  end

  // stage item leaves when it yields no report or the output slot can take it
  assign adv      = s1_valid_r && (!res_valid || out_free);
  assign in_stall = s1_valid_r && !adv;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.mode         <= in_mode;
      s1_item_r.now_time     <= in_now_time;
      s1_item_r.module_index <= in_module_index;
      s1_item_r.input_bitmap <= in_input_bitmap;
    end
  end

  ochr_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .item         (s1_item_r),
    .fire         (adv),
    .max_interval (max_interval_r),
    .min_interval (min_interval_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  ochr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv && res_valid),
    .rep       (res),
    .out_stall (out_stall),
    .free      (out_free),
    .out_valid (out_valid),
    .out_rep   (out_rep)
  );

  assign out_report_module = out_rep.report_module;
  assign out_report_input  = out_rep.report_input;
  assign out_report_value  = out_rep.report_value;

endmodule

`default_nettype wire

// ===== rtl/ochr_core.sv =====
`default_nettype none

module ochr_core
  import ochr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire item_t            item,
  input  wire logic             fire,
  input  wire logic [REG_W-1:0] max_interval,
  input  wire logic [REG_W-1:0] min_interval,
  output      logic             res_valid,
  output      report_t          res
);

  phase_t                       phase_r, phase_nxt;
  logic [TOTAL_INPUTS-1:0]      latest_r, latest_nxt;
  logic [TOTAL_INPUTS-1:0]      reported_r, reported_nxt;
  logic [TIME_W-1:0]            refresh_r [TOTAL_INPUTS];
  logic [TIME_W-1:0]            refresh_nxt [TOTAL_INPUTS];
  logic [TIME_W-1:0]            holdoff_r, holdoff_nxt;
  logic [POS_W-1:0]             pos_r, pos_nxt;

  logic [POS_W-1:0]             pos;
  logic [TIME_W-1:0]            max_dl;
  logic [TIME_W-1:0]            min_dl;
  logic                         changed;
  logic                         expired;

  assign max_dl  = item.now_time + TIME_W'(max_interval);
  assign min_dl  = item.now_time + TIME_W'(min_interval);
  assign pos     = (32'(pos_r) >= TOTAL_INPUTS) ? '0 : pos_r;
  assign changed = latest_r[pos] != reported_r[pos];
  assign expired = time_passed(item.now_time, refresh_r[pos]);

  assign res_valid = (item.mode == MODE_SCAN) && (phase_r == PH_SCAN) && (changed || expired);
  assign res.report_module = MOD_W'(pos / INPUTS_PER_MODULE);
  assign res.report_input  = INP_W'(pos % INPUTS_PER_MODULE);
  assign res.report_value  = latest_r[pos];

  always_comb begin
    phase_nxt    = phase_r;
    latest_nxt   = latest_r;
    reported_nxt = reported_r;
    refresh_nxt  = refresh_r;
    holdoff_nxt  = holdoff_r;
    pos_nxt      = pos_r;
    if (item.mode == MODE_STATUS) begin
      if (32'(item.module_index) < MODULES) begin
        for (int j = 0; j < TOTAL_INPUTS; j++) begin
          if (j / INPUTS_PER_MODULE == 32'(item.module_index)) begin
            latest_nxt[j] = (j % INPUTS_PER_MODULE < BITMAP_W) ?
                            item.input_bitmap[(j % INPUTS_PER_MODULE) % BITMAP_W] : 1'b0;
          end
        end
      end
    end else begin
      case (phase_r)
        PH_INIT: begin
          for (int j = 0; j < TOTAL_INPUTS; j++) begin
            refresh_nxt[j] = max_dl;
          end
          pos_nxt   = '0;
          phase_nxt = PH_SCAN;
        end
        PH_HOLD: begin
          if (time_passed(item.now_time, holdoff_r)) begin
            phase_nxt = PH_SCAN;
          end
        end
        PH_SCAN: begin
          reported_nxt[pos] = latest_r[pos];
          pos_nxt = (32'(pos) == TOTAL_INPUTS - 1) ? '0 : pos + POS_W'(1);
          if (changed || expired) begin
            holdoff_nxt    = min_dl;
            refresh_nxt[pos] = max_dl;
            phase_nxt      = PH_HOLD;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_INIT;
      latest_r   <= '0;
      reported_r <= '0;
      holdoff_r  <= '0;
      pos_r      <= '0;
      for (int j = 0; j < TOTAL_INPUTS; j++) begin
        refresh_r[j] <= '0;
      end
    end else if (fire) begin
      phase_r    <= phase_nxt;
      latest_r   <= latest_nxt;
      reported_r <= reported_nxt;
      holdoff_r  <= holdoff_nxt;
      pos_r      <= pos_nxt;
      refresh_r  <= refresh_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ochr_out_reg.sv =====
`default_nettype none

module ochr_out_reg
  import ochr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire report_t rep,
  input  wire logic    out_stall,
  output      logic    free,
  output      logic    out_valid,
  output      report_t out_rep
);

  logic    valid_r, valid_nxt;
  report_t rep_r;

  // slot can take a new result if empty or being drained this cycle
  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rep_r <= rep;
    end
  end

  assign out_valid = valid_r;
  assign out_rep   = rep_r;

endmodule

`default_nettype wire
